// ===== hdl/rgb_three_kernel_window_filter_core_assert.svh =====
// Assertion macros for the three-kernel window filter.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef RGB_THREE_KERNEL_WINDOW_FILTER_CORE_ASSERT_SVH
`define RGB_THREE_KERNEL_WINDOW_FILTER_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge outside reset.
`define RTKWF_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define RTKWF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ===== hdl/rtkwf_pkg.sv =====
// Shared types, constants and kernel tables for the three-kernel window filter.
// No dependencies; imported by the top level, the lane and the merge modules.
package rtkwf_pkg;

	localparam int MaxWidth  = 2048;
	localparam int MaxHeight = 4096;
	localparam int ColW      = $clog2(MaxWidth);
	localparam int RowW      = $clog2(MaxHeight);
	localparam int WidthRegW  = ColW + 1;
	localparam int HeightRegW = RowW + 1;
	localparam int CfgDataW   = HeightRegW;
	localparam int CfgIndexW  = 2;

	localparam logic [WidthRegW-1:0]  ResetWidth  = WidthRegW'(640);
	localparam logic [HeightRegW-1:0] ResetHeight = HeightRegW'(480);
	localparam logic [WidthRegW-1:0]  MinWidth    = WidthRegW'(3);
	localparam logic [HeightRegW-1:0] MinHeight   = HeightRegW'(3);
	localparam logic [WidthRegW-1:0]  TopWidth    = WidthRegW'(MaxWidth);
	localparam logic [HeightRegW-1:0] TopHeight   = HeightRegW'(MaxHeight);

	// Configuration register indexes
	localparam logic [CfgIndexW-1:0] RegFrameWidth  = 2'd0;
	localparam logic [CfgIndexW-1:0] RegFrameHeight = 2'd1;

	// Kernel selection for a lane
	typedef logic [1:0] kernel_t;
	localparam kernel_t KernelSobel = 2'd0;
	localparam kernel_t KernelGauss = 2'd1;
	localparam kernel_t KernelBox   = 2'd2;

	localparam int SumW = 13;
	// floor(x * BoxRecip / 2**16) equals floor(x / 9) for all box sums
	localparam logic [12:0] BoxRecip = 13'd7282;
	localparam int BoxShift = 16;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [RowW-1:0] center_row;
		logic [ColW-1:0] center_column;
		logic            last;
	} meta_t;

	// Tap weights, index row*3+col, row 0 oldest, col 0 left
	localparam logic signed [3:0] SobelW [9] = '{4'sd1, 4'sd0, -4'sd1,
	                                             4'sd2, 4'sd0, -4'sd2,
	                                             4'sd1, 4'sd0, -4'sd1};
	localparam logic signed [3:0] GaussW [9] = '{4'sd1, 4'sd2, 4'sd1,
	                                             4'sd2, 4'sd4, 4'sd2,
	                                             4'sd1, 4'sd2, 4'sd1};
	localparam logic signed [3:0] BoxW   [9] = '{4'sd1, 4'sd1, 4'sd1,
	                                             4'sd1, 4'sd1, 4'sd1,
	                                             4'sd1, 4'sd1, 4'sd1};

	function automatic logic signed [SumW-1:0] kernel_weight(kernel_t k, int tap);
		logic signed [3:0] w;
		case (k)
			KernelSobel: w = SobelW[tap];
			KernelGauss: w = GaussW[tap];
			KernelBox:   w = BoxW[tap];
			default:     w = 4'sd0;
		endcase
		return SumW'(w);
	endfunction

	function automatic logic [WidthRegW-1:0] clamp_width(logic [WidthRegW-1:0] v);
		if (v < MinWidth) begin
			return MinWidth;
		end else if (v > TopWidth) begin
			return TopWidth;
		end
		return v;
	endfunction

	function automatic logic [HeightRegW-1:0] clamp_height(logic [HeightRegW-1:0] v);
		if (v < MinHeight) begin
			return MinHeight;
		end else if (v > TopHeight) begin
			return TopHeight;
		end
		return v;
	endfunction

endpackage

// ===== hdl/rgb_three_kernel_window_filter_core.sv =====
// Top level of the three-kernel 3x3 window filter: counters, line stores, window, lanes.
// Depends on rtkwf_pkg, rtkwf_ram, rtkwf_lane, rtkwf_merge and the assertion header.
//
//  channel  | handshake                    | payload
//  ---------+------------------------------+------------------------------------------
//  pixel    | pixel_valid / pixel_stall    | blue_in, green_in, red_in
//  result   | result_valid / result_stall  | blue_out, green_out, red_out,
//           |                              | center_row, center_column, last_of_frame
//  config   | write_enable                 | write_index, write_data
//
// One pixel is taken per clock while pixel_stall is low; a result passes from the
// line-store read through the window register, the two lane stages and the output register.
// The whole pipeline freezes and pixel_stall rises only while a result waits under
// result_stall. Reset clears counters, window and valid bits; the line stores are not
// cleared, and entries read before being written feed only border windows, which give no result.
`include "rgb_three_kernel_window_filter_core_assert.svh"

module rgb_three_kernel_window_filter_core import rtkwf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pixel_valid,
	output logic                 pixel_stall,
	input  logic [7:0]           blue_in,
	input  logic [7:0]           green_in,
	input  logic [7:0]           red_in,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [7:0]           blue_out,
	output logic [7:0]           green_out,
	output logic [7:0]           red_out,
	output logic [RowW-1:0]      center_row,
	output logic [ColW-1:0]      center_column,
	output logic                 last_of_frame,
	input  logic                 write_enable,
	input  logic [CfgIndexW-1:0] write_index,
	input  logic [CfgDataW-1:0]  write_data
);

	logic [WidthRegW-1:0]  width_q;
	logic [HeightRegW-1:0] height_q;
	logic [ColW-1:0]       col_q;
	logic [RowW-1:0]       row_q;
	logic [WidthRegW-1:0]  col_next;
	logic [HeightRegW-1:0] row_next;
	logic                  restart;
	logic                  en;
	logic                  accept;

	logic      v_s1, int_s1, v_s2, v_s3, v_s4;
	pixel_t    px_s1;
	logic [ColW-1:0] col_s1;
	meta_t     meta_s1, meta_s2, meta_s3, meta_s4;
	pixel_t    pixel_in;
	logic [23:0] older_rd, newer_rd;
	pixel_t    win_q [9];
	logic [7:0] blue_taps [9];
	logic [7:0] green_taps [9];
	logic [7:0] red_taps [9];
	logic [7:0] blue_s4, green_s4, red_s4;

	assign en          = !result_valid || !result_stall;
	assign pixel_stall = !en;
	assign accept      = pixel_valid && en;
	assign restart     = write_enable &&
	                     (write_index == RegFrameWidth || write_index == RegFrameHeight);
	assign col_next    = {1'b0, col_q} + WidthRegW'(1);
	assign row_next    = {1'b0, row_q} + HeightRegW'(1);
	assign pixel_in    = '{red: red_in, green: green_in, blue: blue_in};

	// Write configuration registers, saturated to the legal range
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ResetWidth;
			height_q <= ResetHeight;
		end else if (write_enable) begin
			if (write_index == RegFrameWidth) begin
				width_q <= clamp_width(write_data[WidthRegW-1:0]);
			end else if (write_index == RegFrameHeight) begin
				height_q <= clamp_height(write_data);
			end
		end
	end

	// Advance raster position on each accepted pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (col_next >= width_q) begin
				col_q <= '0;
				if (row_next >= height_q) begin
					row_q <= '0;
				end else begin
					row_q <= row_next[RowW-1:0];
				end
			end else begin
				col_q <= col_next[ColW-1:0];
			end
		end
	end

	// Stage 1: capture the pixel while the line stores are read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1                 <= pixel_in;
			col_s1                <= col_q;
			int_s1                <= (row_q >= RowW'(2)) && (col_q >= ColW'(2));
			meta_s1.center_row    <= row_q - RowW'(1);
			meta_s1.center_column <= col_q - ColW'(1);
			meta_s1.last          <= (row_next == height_q) && (col_next == width_q);
		end
	end

	// Row r-2: takes the row r-1 entry once it has been read
	rtkwf_ram #(.WIDTH(24), .DEPTH(MaxWidth)) u_older_store (
		.clk   (clk),
		.we    (en && v_s1),
		.waddr (col_s1),
		.wdata (newer_rd),
		.re    (accept),
		.raddr (col_q),
		.rdata (older_rd)
	);

	// Row r-1: takes the incoming pixel
	rtkwf_ram #(.WIDTH(24), .DEPTH(MaxWidth)) u_newer_store (
		.clk   (clk),
		.we    (accept),
		.waddr (col_q),
		.wdata (pixel_in),
		.re    (accept),
		.raddr (col_q),
		.rdata (newer_rd)
	);

	// Shift the window left and insert the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (restart) begin
			for (int k = 0; k < 9; k++) begin
				win_q[k] <= '0;
			end
		end else if (en && v_s1) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= older_rd;
			win_q[5] <= newer_rd;
			win_q[8] <= px_s1;
		end
	end

	// Carry valid and coordinates alongside the window and lane stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && int_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			meta_s2 <= meta_s1;
			meta_s3 <= meta_s2;
			meta_s4 <= meta_s3;
		end
	end

	// Split the window into per-channel taps
	always_comb begin
		for (int k = 0; k < 9; k++) begin
			blue_taps[k]  = win_q[k].blue;
			green_taps[k] = win_q[k].green;
			red_taps[k]   = win_q[k].red;
		end
	end

	rtkwf_lane u_blue_lane (
		.clk       (clk),
		.en        (en),
		.kernel    (KernelSobel),
		.taps      (blue_taps),
		.result_s4 (blue_s4)
	);

	rtkwf_lane u_green_lane (
		.clk       (clk),
		.en        (en),
		.kernel    (KernelGauss),
		.taps      (green_taps),
		.result_s4 (green_s4)
	);

	rtkwf_lane u_red_lane (
		.clk       (clk),
		.en        (en),
		.kernel    (KernelBox),
		.taps      (red_taps),
		.result_s4 (red_s4)
	);

	rtkwf_merge u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.v_s4          (v_s4),
		.meta_s4       (meta_s4),
		.blue_s4       (blue_s4),
		.green_s4      (green_s4),
		.red_s4        (red_s4),
		.result_valid  (result_valid),
		.blue_out      (blue_out),
		.green_out     (green_out),
		.red_out       (red_out),
		.center_row    (center_row),
		.center_column (center_column),
		.last_of_frame (last_of_frame)
	);

	// Raster position stays inside the configured frame
	`RTKWF_ASSERT_HOLDS(a_col_in_frame, clk, arst_n, {1'b0, col_q} < width_q, "column past frame width")
	`RTKWF_ASSERT_HOLDS(a_row_in_frame, clk, arst_n, {1'b0, row_q} < height_q, "row past frame height")
	// A result always names an interior pixel
	`RTKWF_ASSERT_IMPLIES(a_result_interior, clk, arst_n, result_valid, center_row != '0 && center_column != '0, "result on border pixel")

endmodule

// ===== hdl/rtkwf_ram.sv =====
// Generic single-write, single-read RAM with registered, read-first output.
// No dependencies; used for both line stores.
module rtkwf_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and read; a read at the written address returns the old entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/rtkwf_lane.sv =====
// One filter lane: weighted 3x3 sum, then clamp, shift or divide by nine.
// Depends on rtkwf_pkg for kernel codes and weight tables.
module rtkwf_lane import rtkwf_pkg::*; (
	input  logic       clk,
	input  logic       en,
	input  kernel_t    kernel,
	input  logic [7:0] taps [9],
	output logic [7:0] result_s4
);

	logic signed [SumW-1:0] sum_comb;
	logic signed [SumW-1:0] sum_s3;
	logic [7:0]             post_comb;
	logic [24:0]            box_prod;

	// Form the weighted sum of the nine taps
	always_comb begin
		sum_comb = '0;
		for (int k = 0; k < 9; k++) begin
			sum_comb = sum_comb + $signed({5'b0, taps[k]}) * kernel_weight(kernel, k);
		end
	end

	assign box_prod = {12'b0, sum_s3[11:0]} * {12'b0, BoxRecip};

	// Reduce the sum to one byte
	always_comb begin
		case (kernel)
			KernelSobel: begin
				if (sum_s3 < 0) begin
					post_comb = 8'd0;
				end else if (sum_s3 > 13'sd255) begin
					post_comb = 8'd255;
				end else begin
					post_comb = sum_s3[7:0];
				end
			end
			KernelGauss: post_comb = sum_s3[11:4];
			KernelBox:   post_comb = box_prod[BoxShift+7:BoxShift];
			default:     post_comb = 8'd0;
		endcase
	end

	// Advance both stages with the pipeline
	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3    <= sum_comb;
			result_s4 <= post_comb;
		end
	end

endmodule

// ===== hdl/rtkwf_merge.sv =====
// Merging stage: joins the three lane results with coordinates in the output register.
// Depends on rtkwf_pkg for meta_t.
module rtkwf_merge import rtkwf_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            v_s4,
	input  meta_t           meta_s4,
	input  logic [7:0]      blue_s4,
	input  logic [7:0]      green_s4,
	input  logic [7:0]      red_s4,
	output logic            result_valid,
	output logic [7:0]      blue_out,
	output logic [7:0]      green_out,
	output logic [7:0]      red_out,
	output logic [RowW-1:0] center_row,
	output logic [ColW-1:0] center_column,
	output logic            last_of_frame
);

	logic valid_q;

	// Load a new transaction whenever the output side can move
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= v_s4;
		end
	end

	// Hold the payload until the transaction is taken
	always_ff @(posedge clk) begin
		if (en && v_s4) begin
			blue_out      <= blue_s4;
			green_out     <= green_s4;
			red_out       <= red_s4;
			center_row    <= meta_s4.center_row;
			center_column <= meta_s4.center_column;
			last_of_frame <= meta_s4.last;
		end
	end

	assign result_valid = valid_q;

endmodule
